// File: hw/rtl/ray_box_entry_exit_macros.svh
// ============================================================================
// ray_box_entry_exit_macros.svh
// Assertion shorthands shared by the line/box intersection RTL.
// ============================================================================
`ifndef RAY_BOX_ENTRY_EXIT_MACROS_SVH
`define RAY_BOX_ENTRY_EXIT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define RBEE_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// pre at one edge implies post at the next edge
`define RBEE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/rbee_pkg.sv
// ============================================================================
// rbee_pkg
// Shared constants and register codes for the line/box intersection block.
// ============================================================================
package rbee_pkg;

    localparam int N_AXES    = 3;
    localparam int N_FACES   = 6;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MAX_X = 3'd1,
        CFG_MIN_Y = 3'd2,
        CFG_MAX_Y = 3'd3,
        CFG_MIN_Z = 3'd4,
        CFG_MAX_Z = 3'd5
    } t_cfg_idx;

endpackage

// File: hw/rtl/rbee_face.sv
// ============================================================================
// rbee_face
// One box face: line parameter by pipelined restoring division, saturation,
// crossing point on the other two axes and the strict inside test.
// ============================================================================
module rbee_face #(
    parameter int COORD_WIDTH = 32,
    parameter int AXIS        = 0,
    parameter int SIDE        = 0
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic [rbee_pkg::N_FACES-1:0][COORD_WIDTH-1:0] i_box,
    input  logic [rbee_pkg::N_AXES-1:0][COORD_WIDTH-1:0]  i_org,
    input  logic [rbee_pkg::N_AXES-1:0][COORD_WIDTH-1:0]  i_dir,
    input  logic [rbee_pkg::N_AXES-1:0][COORD_WIDTH-1:0]  i_dir_mul,
    input  logic [rbee_pkg::N_AXES-1:0][COORD_WIDTH-1:0]  i_org_add,
    input  logic [rbee_pkg::N_AXES-1:0][COORD_WIDTH-1:0]  i_dir_add,
    output logic                                     o_ok,
    output logic [rbee_pkg::N_AXES-1:0][COORD_WIDTH-1:0]  o_pt
);
    import rbee_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int F  = COORD_WIDTH / 2;
    localparam int SH = W - F;
    localparam int PW = 2 * W - F + 2;
    localparam int FI = 2 * AXIS + SIDE;

    // stage 1: magnitudes and sign of t
    logic [W:0]   w_num;
    logic [W:0]   r_nmag;
    logic [W-1:0] w_dmag;
    logic [W-1:0] r_dmag1;
    logic         r_tn1, r_nz1;

    assign w_num  = {i_box[FI][W-1], i_box[FI]} - {i_org[AXIS][W-1], i_org[AXIS]};
    assign w_dmag = i_dir[AXIS][W-1] ? (~i_dir[AXIS] + 1'b1) : i_dir[AXIS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nmag  <= w_num[W] ? (~w_num + 1'b1) : w_num;
            r_dmag1 <= w_dmag;
            r_tn1   <= w_num[W] ^ i_dir[AXIS][W-1];
            r_nz1   <= |i_dir[AXIS];
        end
    end

    // stage 2 .. W+2: overflow check, then one quotient bit per stage
    logic [W-1:0] r_rem [0:W];
    logic [W-1:0] r_low [0:W];
    logic [W-1:0] r_q   [0:W];
    logic [W-1:0] r_d   [0:W];
    logic         r_tn  [0:W];
    logic         r_nz  [0:W];
    logic         r_ovf [0:W];
    logic [F:0]   w_hi;

    assign w_hi = r_nmag[W:SH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= W'(w_hi);
            r_low[0] <= {r_nmag[SH-1:0], {F{1'b0}}};
            r_q[0]   <= '0;
            r_d[0]   <= r_dmag1;
            r_tn[0]  <= r_tn1;
            r_nz[0]  <= r_nz1;
            r_ovf[0] <= (W+1)'(w_hi) >= {1'b0, r_dmag1};
        end
    end

    for (genvar j = 1; j <= W; j++) begin : g_div
        logic [W:0] w_r2;
        logic       w_ge;
        logic [W:0] w_diff;

        assign w_r2   = {r_rem[j-1], r_low[j-1][W-1]};
        assign w_ge   = w_r2 >= {1'b0, r_d[j-1]};
        assign w_diff = w_r2 - {1'b0, r_d[j-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? w_diff[W-1:0] : w_r2[W-1:0];
                r_low[j] <= {r_low[j-1][W-2:0], 1'b0};
                r_q[j]   <= {r_q[j-1][W-2:0], w_ge};
                r_d[j]   <= r_d[j-1];
                r_tn[j]  <= r_tn[j-1];
                r_nz[j]  <= r_nz[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    // stage W+3: saturate t
    logic [W-1:0] w_lim;
    logic [W-1:0] r_tmag;
    logic         r_tn3, r_nz3;

    assign w_lim = r_tn[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tmag <= (r_ovf[W] || (r_q[W] > w_lim)) ? w_lim : r_q[W];
            r_tn3  <= r_tn[W];
            r_nz3  <= r_nz[W];
        end
    end

    // stage W+4: products; stage W+5: crossing points and inside test
    logic [2*W-1:0] r_p   [0:1];
    logic           r_tn4, r_nz4;
    logic [W-1:0]   r_ptb [0:1];
    logic           r_in  [0:1];
    logic [W-1:0]   r_face;
    logic           r_nz5;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tn4  <= r_tn3;
            r_nz4  <= r_nz3;
            r_nz5  <= r_nz4;
            r_face <= i_box[FI];
        end
    end

    for (genvar i = 0; i < 2; i++) begin : g_oth
        localparam int B = (AXIS + 1 + i) % N_AXES;

        logic [W-1:0]     w_dm;
        logic [PW-1:0]    w_ext;
        logic [PW-1:0]    w_off;
        logic signed [PW-1:0] w_pt;
        logic signed [PW-1:0] w_lo;
        logic signed [PW-1:0] w_hi_b;

        assign w_dm   = i_dir_mul[B][W-1] ? (~i_dir_mul[B] + 1'b1) : i_dir_mul[B];
        assign w_ext  = PW'(r_p[i][2*W-1:F]);
        assign w_off  = (r_tn4 ^ i_dir_add[B][W-1]) ? (~w_ext + 1'b1) : w_ext;
        assign w_pt   = $signed({{(PW-W){i_org_add[B][W-1]}}, i_org_add[B]} + w_off);
        assign w_lo   = $signed({{(PW-W){i_box[2*B][W-1]}}, i_box[2*B]});
        assign w_hi_b = $signed({{(PW-W){i_box[2*B+1][W-1]}}, i_box[2*B+1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[i]   <= (2*W)'(r_tmag) * (2*W)'(w_dm);
                r_ptb[i] <= w_pt[W-1:0];
                r_in[i]  <= (w_lo < w_pt) && (w_pt < w_hi_b);
            end
        end
    end

    always_comb begin
        o_pt                           = '0;
        o_pt[AXIS]                     = r_face;
        o_pt[(AXIS + 1) % N_AXES]      = r_ptb[0];
        o_pt[(AXIS + 2) % N_AXES]      = r_ptb[1];
    end

    assign o_ok = r_nz5 && r_in[0] && r_in[1];

endmodule

// File: hw/rtl/ray_box_entry_exit.sv
// ============================================================================
// ray_box_entry_exit
// Line versus axis-aligned box: entry and exit crossings of a ray's line.
// ============================================================================
// Usage:
//   Box bounds are written over the cfg channel (index 0..5: min/max x, y, z);
//   the user writes them only while no ray is in flight, which the block does not enforce; indexes 6 and 7 are ignored.
//   Rays enter on the s channel (origin x,y,z then dir x,y,z in tdata).
//   Results leave on the m channel: tdata carries entry x,y,z then exit
//   x,y,z, tuser carries hit. Without a hit all points read zero.
//   Throughput: one ray per cycle while the skid stage is empty. From acceptance
//   a ray passes the input register and the six face dividers, which produce one
//   quotient bit per stage, followed by saturation, multiply, add/compare
//   and the output register.
//   Stall: the output register has a one-item skid stage behind it; when the
//   receiver holds i_m_tready low and the skid fills, the whole pipeline and
//   o_s_tready freeze until the skid drains. No item is lost or repeated.
//   Reset: i_rst_n low clears all valid bits and sets every bound to zero.
// ============================================================================
`include "ray_box_entry_exit_macros.svh"

module ray_box_entry_exit #(
    parameter int COORD_WIDTH = 32,
    localparam int DW = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [DW-1:0]                  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // entry_x, entry_y, entry_z, exit_x, exit_y, exit_z
    output logic [DW-1:0]                  o_m_tdata,
    // hit
    output logic                           o_m_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rbee_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_WIDTH-1:0]         i_cfg_data
);
    import rbee_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int K  = W + 5;
    localparam int DL = W + 5;

    logic [N_FACES-1:0][W-1:0] r_box;
    logic [K:0]                r_v;
    logic [N_AXES-1:0][W-1:0]  r_org [0:DL-1];
    logic [N_AXES-1:0][W-1:0]  r_dir [0:DL-1];
    logic                      w_en;
    logic                      w_dv;

    logic [N_FACES-1:0]                  w_ok;
    logic [N_AXES-1:0][W-1:0]            w_pt [0:N_FACES-1];
    logic [2:0]                          w_cnt;
    logic [N_FACES-1:0]                  w_sel0, w_sel1;
    logic [N_AXES-1:0][W-1:0]            w_entry, w_exit;
    logic                                w_hit;
    logic [6*W-1:0]                      w_res;

    logic [6*W-1:0] r_o_data, r_sk_data;
    logic           r_o_hit, r_sk_hit;
    logic           r_o_v, r_sk_v;

    assign w_en        = !r_sk_v;
    assign w_dv        = w_en && r_v[K];
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_o_v;
    assign o_m_tdata   = DW'(r_o_data);
    assign o_m_tuser   = r_o_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box  <= '0;
            r_v    <= '0;
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_X: r_box[0] <= i_cfg_data;
                    CFG_MAX_X: r_box[1] <= i_cfg_data;
                    CFG_MIN_Y: r_box[2] <= i_cfg_data;
                    CFG_MAX_Y: r_box[3] <= i_cfg_data;
                    CFG_MIN_Z: r_box[4] <= i_cfg_data;
                    CFG_MAX_Z: r_box[5] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_en) begin
                r_v <= {r_v[K-1:0], i_s_tvalid};
            end
            if (!r_o_v || i_m_tready) begin
                r_o_v  <= r_sk_v || w_dv;
                r_sk_v <= 1'b0;
            end else if (w_dv) begin
                r_sk_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < N_AXES; a++) begin
                r_org[0][a] <= i_s_tdata[a*W +: W];
                r_dir[0][a] <= i_s_tdata[(a+N_AXES)*W +: W];
            end
            for (int k = 1; k < DL; k++) begin
                r_org[k] <= r_org[k-1];
                r_dir[k] <= r_dir[k-1];
            end
        end
        if (!r_o_v || i_m_tready) begin
            r_o_data <= r_sk_v ? r_sk_data : w_res;
            r_o_hit  <= r_sk_v ? r_sk_hit : w_hit;
        end else if (w_dv) begin
            r_sk_data <= w_res;
            r_sk_hit  <= w_hit;
        end
    end

    for (genvar f = 0; f < N_FACES; f++) begin : g_face
        rbee_face #(
            .COORD_WIDTH (W),
            .AXIS        (f / 2),
            .SIDE        (f % 2)
        ) u_face (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_box     (r_box),
            .i_org     (r_org[0]),
            .i_dir     (r_dir[0]),
            .i_dir_mul (r_dir[W+3]),
            .i_org_add (r_org[W+4]),
            .i_dir_add (r_dir[W+4]),
            .o_ok      (w_ok[f]),
            .o_pt      (w_pt[f])
        );
    end

    always_comb begin
        w_cnt   = '0;
        w_sel0  = '0;
        w_sel1  = '0;
        w_entry = '0;
        w_exit  = '0;
        for (int f = 0; f < N_FACES; f++) begin
            if (w_ok[f]) begin
                if (w_cnt == 3'd0) begin
                    w_sel0[f] = 1'b1;
                end else if (w_cnt == 3'd1) begin
                    w_sel1[f] = 1'b1;
                end
                w_cnt = w_cnt + 3'd1;
            end
        end
        for (int f = 0; f < N_FACES; f++) begin
            if (w_sel0[f]) begin
                w_entry = w_entry | w_pt[f];
            end
            if (w_sel1[f]) begin
                w_exit = w_exit | w_pt[f];
            end
        end
        w_hit = (w_cnt == 3'd2);
        w_res = w_hit ? {w_exit, w_entry} : '0;
    end

    `RBEE_ASSERT_HOLD(a_skid_needs_out, !r_sk_v || r_o_v, "skid full, output empty")
    `RBEE_ASSERT_NEXT(a_skid_fill, r_o_v && !i_m_tready && r_v[K] && !r_sk_v, r_sk_v, "skid missed")
    `RBEE_ASSERT_NEXT(a_skid_drain, r_sk_v && i_m_tready, !r_sk_v && r_o_v, "skid did not drain")
    `RBEE_ASSERT_HOLD(a_miss_zero, !r_o_v || r_o_hit || (r_o_data == '0), "miss with nonzero points")

endmodule
